@@ rtl/core/text_console_writer_assert.svh @@
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Shared assertion forms for the checker of the text console writer.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Property checked on every rising edge while reset is released.
`define TCW_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("text console writer: assertion failed");

// Property checked on every rising edge, reset included.
`define TCW_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("text console writer: assertion failed during reset");

`endif

@@ rtl/core/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// Text console writer package
// Types, codes and constants shared by the console writer modules.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Default screen geometry.
    localparam int DEFAULT_COLUMNS = 80;
    localparam int DEFAULT_ROWS    = 25;

    // Port field widths.
    localparam int ACTION_W     = 2;
    localparam int CHAR_W       = 8;
    localparam int COLOR_W      = 8;
    localparam int READ_ROW_W   = 5;
    localparam int READ_COL_W   = 7;
    localparam int CELL_VALUE_W = 16;
    localparam int CURSOR_ROW_W = 5;
    localparam int CURSOR_COL_W = 7;

    // Cell address width large enough for the largest supported grid.
    localparam int ADDR_W = 15;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Character and color codes.
    localparam logic [CHAR_W-1:0]  NEWLINE_CODE     = 8'd10;
    localparam logic [CHAR_W-1:0]  BLANK_CODE       = 8'd32;
    localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 8'd7;

    // Request action codes.
    typedef enum logic [ACTION_W-1:0] {
        ACT_PUT   = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

    // Classified command kinds handed to the back end.
    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_PUT,
        CMD_NEWLINE,
        CMD_READ,
        CMD_CLEAR
    } cmd_kind_t;

    // One queued command.
    typedef struct packed {
        cmd_kind_t          kind;
        logic [CHAR_W-1:0]  char_code;
        logic [ADDR_W-1:0]  addr;
    } cmd_entry_t;

    // Queue head as seen by the back end.
    typedef struct packed {
        logic       valid;
        cmd_entry_t entry;
    } cmd_slot_t;

    // Back end sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_WAIT,
        ST_SCROLL,
        ST_FILL
    } back_state_t;

endpackage

@@ rtl/core/tcw_front.sv @@
// ----------------------------------------------------------------------------
// Text console writer front end
// Accepts requests and classifies them into commands for the queue.
// ----------------------------------------------------------------------------
module tcw_front
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEFAULT_COLUMNS,
    parameter int ROWS    = DEFAULT_ROWS
) (
    input  logic                  start,
    input  logic                  full,
    input  logic [ACTION_W-1:0]   action,
    input  logic [CHAR_W-1:0]     char_code,
    input  logic [READ_ROW_W-1:0] read_row,
    input  logic [READ_COL_W-1:0] read_col,
    output logic                  push,
    output cmd_entry_t            entry
);

    logic read_in_range;

    // A request is taken whenever the queue has room.
    assign push = start && !full;

    // Reads outside the grid change nothing and return zero.
    assign read_in_range = (32'(read_row) < 32'(ROWS)) && (32'(read_col) < 32'(COLUMNS));

    // Classify the request and form the read address.
    always_comb
    begin
        entry.char_code = char_code;
        entry.addr      = ADDR_W'(read_row) * ADDR_W'(COLUMNS) + ADDR_W'(read_col);
        case (action)
            ACT_PUT:
            begin
                entry.kind = (char_code == NEWLINE_CODE) ? CMD_NEWLINE : CMD_PUT;
            end
            ACT_READ:
            begin
                entry.kind = read_in_range ? CMD_READ : CMD_NOP;
            end
            ACT_CLEAR:
            begin
                entry.kind = CMD_CLEAR;
            end
            default:
            begin
                entry.kind = CMD_NOP;
            end
        endcase
    end

endmodule

@@ rtl/core/tcw_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// Text console writer command queue
// Short queue that decouples request intake from command execution.
// ----------------------------------------------------------------------------
module tcw_cmd_fifo
    import tcw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  cmd_entry_t push_entry,
    input  logic       pop,
    output cmd_slot_t  head,
    output logic       full
);

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_entry_t           slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic                 do_pop;

    // Status toward both sides.
    assign full       = (count_reg == COUNT_W'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.entry = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    // Pointer and count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ rtl/core/tcw_back.sv @@
// ----------------------------------------------------------------------------
// Text console writer back end
// Owns the cell memory and the cursor and carries out queued commands.
// ----------------------------------------------------------------------------
module tcw_back
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEFAULT_COLUMNS,
    parameter int ROWS    = DEFAULT_ROWS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_slot_t                head,
    input  logic [COLOR_W-1:0]       color,
    output logic                     pop,
    output logic                     done,
    output logic [CELL_VALUE_W-1:0]  cell_value,
    output logic [$clog2(ROWS)-1:0]  cursor_row,
    output logic [$clog2(COLUMNS)-1:0] cursor_col
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int CELL_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);

    back_state_t              state_reg;
    back_state_t              state_next;
    logic [CELL_W-1:0]        cnt_reg;
    logic [CELL_W-1:0]        cnt_next;
    logic [ROW_W-1:0]         row_reg;
    logic [ROW_W-1:0]         row_next;
    logic [COL_W-1:0]         col_reg;
    logic [COL_W-1:0]         col_next;
    logic                     done_reg;
    logic                     done_next;
    logic [CELL_VALUE_W-1:0]  cell_value_reg;
    logic [CELL_VALUE_W-1:0]  cell_value_next;
    logic [CELL_VALUE_W-1:0]  rdata_reg;
    logic [CELL_VALUE_W-1:0]  mem [CELLS];

    logic                     mem_we;
    logic [CELL_W-1:0]        mem_waddr;
    logic [CELL_VALUE_W-1:0]  mem_wdata;
    logic                     mem_re;
    logic [CELL_W-1:0]        mem_raddr;

    logic                     is_advance;
    logic                     wraps;
    logic                     on_last_row;
    logic                     scroll_last;
    logic                     fill_last;
    logic [CELL_W-1:0]        cursor_addr;

    // Decode of the head command and the cursor position.
    assign is_advance  = (head.entry.kind == CMD_PUT) || (head.entry.kind == CMD_NEWLINE);
    assign wraps       = (head.entry.kind == CMD_NEWLINE) || (col_reg == COL_W'(COLUMNS - 1));
    assign on_last_row = (row_reg == ROW_W'(ROWS - 1));
    assign scroll_last = (cnt_reg == CELL_W'(CELLS - COLUMNS));
    assign fill_last   = (cnt_reg == CELL_W'(CELLS - 1));
    assign cursor_addr = CELL_W'(row_reg) * CELL_W'(COLUMNS) + CELL_W'(col_reg);

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    if (head.entry.kind == CMD_READ)
                    begin
                        state_next = ST_READ_WAIT;
                    end
                    else if (head.entry.kind == CMD_CLEAR)
                    begin
                        state_next = ST_FILL;
                    end
                    else if (is_advance && wraps && on_last_row)
                    begin
                        state_next = ST_SCROLL;
                    end
                end
            end
            ST_READ_WAIT:
            begin
                state_next = ST_IDLE;
            end
            ST_SCROLL:
            begin
                if (scroll_last)
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (fill_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: memory access, cursor, counter and result.
    always_comb
    begin
        pop             = 1'b0;
        cnt_next        = cnt_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        done_next       = 1'b0;
        cell_value_next = '0;
        mem_we          = 1'b0;
        mem_waddr       = cursor_addr;
        mem_wdata       = {color, head.entry.char_code};
        mem_re          = 1'b0;
        mem_raddr       = CELL_W'(head.entry.addr);
        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    case (head.entry.kind)
                        CMD_PUT, CMD_NEWLINE:
                        begin
                            mem_we = (head.entry.kind == CMD_PUT);
                            if (!wraps)
                            begin
                                col_next  = col_reg + 1'b1;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                col_next = '0;
                                if (on_last_row)
                                begin
                                    cnt_next = '0;
                                end
                                else
                                begin
                                    row_next  = row_reg + 1'b1;
                                    done_next = 1'b1;
                                end
                            end
                        end
                        CMD_READ:
                        begin
                            mem_re = 1'b1;
                        end
                        CMD_CLEAR:
                        begin
                            row_next = '0;
                            col_next = '0;
                            cnt_next = '0;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ_WAIT:
            begin
                done_next       = 1'b1;
                cell_value_next = rdata_reg;
            end
            ST_SCROLL:
            begin
                // Read one row below, write back the cell read in the cycle before.
                mem_re    = !scroll_last;
                mem_raddr = cnt_reg + CELL_W'(COLUMNS);
                mem_we    = (cnt_reg != '0);
                mem_waddr = cnt_reg - 1'b1;
                mem_wdata = rdata_reg;
                if (!scroll_last)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = {color, BLANK_CODE};
                if (fill_last)
                begin
                    done_next = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            done_reg  <= done_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        cell_value_reg <= cell_value_next;
    end

    // Cell memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    assign done       = done_reg;
    assign cell_value = cell_value_reg;
    assign cursor_row = row_reg;
    assign cursor_col = col_reg;

endmodule

@@ rtl/core/text_console_writer.sv @@
// ----------------------------------------------------------------------------
// Text console writer
// Character grid with cursor: put character, read cell, clear screen.
//
//   Channel   Handshake              Ports
//   request   start, busy            action, char_code, read_row, read_col
//   result    done (one cycle)       cell_value, cursor_row, cursor_col
//   config    color_we               color_data
//
// A request enters a two-entry command queue and is registered there before
// the back end takes it. A put or newline is carried out in the idle state and
// a read waits in ST_READ_WAIT for the registered cell read. A clear adds a
// pass over all ROWS*COLUMNS cells, and a put that leaves the last row adds a
// scroll pass and a blank fill of the last row, since the cell memory has one
// write port and these passes walk it one cell per cycle.
// Reset clears the cursor, queue and color (to 7); cell contents are
// undefined until the first clear. busy is high while the queue is full.
// ----------------------------------------------------------------------------
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEFAULT_COLUMNS,
    parameter int ROWS    = DEFAULT_ROWS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [ACTION_W-1:0]     action,
    input  logic [CHAR_W-1:0]       char_code,
    input  logic [READ_ROW_W-1:0]   read_row,
    input  logic [READ_COL_W-1:0]   read_col,
    input  logic                    color_we,
    input  logic [COLOR_W-1:0]      color_data,
    output logic                    done,
    output logic [CELL_VALUE_W-1:0] cell_value,
    output logic [CURSOR_ROW_W-1:0] cursor_row,
    output logic [CURSOR_COL_W-1:0] cursor_col
);

    logic [COLOR_W-1:0]          color_reg;
    logic                        push;
    logic                        pop;
    logic                        full;
    cmd_entry_t                  push_entry;
    cmd_slot_t                   head;
    logic [$clog2(ROWS)-1:0]     row_pos;
    logic [$clog2(COLUMNS)-1:0]  col_pos;

    // Text color register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= TEXT_COLOR_RESET;
        end
        else if (color_we)
        begin
            color_reg <= color_data;
        end
    end

    // Request intake and classification.
    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .start     (start),
        .full      (full),
        .action    (action),
        .char_code (char_code),
        .read_row  (read_row),
        .read_col  (read_col),
        .push      (push),
        .entry     (push_entry)
    );

    // Command queue.
    tcw_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (full)
    );

    // Command execution.
    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .color      (color_reg),
        .pop        (pop),
        .done       (done),
        .cell_value (cell_value),
        .cursor_row (row_pos),
        .cursor_col (col_pos)
    );

    assign busy       = full;
    assign cursor_row = CURSOR_ROW_W'(row_pos);
    assign cursor_col = CURSOR_COL_W'(col_pos);

endmodule

@@ rtl/core/tcw_checker.sv @@
// ----------------------------------------------------------------------------
// Text console writer checker
// Port-level assertions on results, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_console_writer_assert.svh"

module tcw_checker
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEFAULT_COLUMNS,
    parameter int ROWS    = DEFAULT_ROWS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    done,
    input  logic [CURSOR_ROW_W-1:0] cursor_row,
    input  logic [CURSOR_COL_W-1:0] cursor_col
);

    // No result may appear in the cycle after reset is seen.
    `TCW_ASSERT_ALWAYS(no_done_after_reset, clk, !rst_n |=> !done)

    // A reported cursor always lies inside the grid.
    `TCW_ASSERT(cursor_row_in_grid, clk, rst_n, done |-> (32'(cursor_row) < 32'(ROWS)))
    `TCW_ASSERT(cursor_col_in_grid, clk, rst_n, done |-> (32'(cursor_col) < 32'(COLUMNS)))

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .done       (done),
    .cursor_row (cursor_row),
    .cursor_col (cursor_col)
);

@@ bench/tb_text_console_writer.sv @@
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives put, read, clear and unused requests into the console writer. A
// shadow copy of the screen, cursor and text color in the bench predicts the
// cell value and cursor position of every result. A short table of requests
// covers the corner cases first. Random requests with random idle gaps then
// run through several text colors. The random part favors runs of characters
// and newlines, so that lines wrap and the screen scrolls many times.
// ----------------------------------------------------------------------------
module tb_text_console_writer;
    import tcw_pkg::*;

    localparam int COLS          = DEFAULT_COLUMNS;
    localparam int ROWS          = DEFAULT_ROWS;
    localparam int COLOR_PHASES  = 6;
    localparam int PHASE_ITEMS   = 222;
    localparam int SEGMENT_ITEMS = 80;
    localparam int STALL_LIMIT   = 50000;
    localparam int TABLE_ROWS    = 20;

    // Action code that the block must ignore.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // What one result shows: the cell read and the cursor after the request.
    typedef struct packed {
        logic [CELL_VALUE_W-1:0] cell_value;
        logic [CURSOR_ROW_W-1:0] cursor_row;
        logic [CURSOR_COL_W-1:0] cursor_col;
    } console_view_t;

    // One row of the directed table; the view is used only when has_view is set.
    typedef struct packed {
        logic [ACTION_W-1:0]   act;
        logic [CHAR_W-1:0]     code;
        logic [READ_ROW_W-1:0] row;
        logic [READ_COL_W-1:0] col;
        logic                  has_view;
        console_view_t         view;
    } directed_row_t;

    localparam console_view_t NO_VIEW = '0;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [ACTION_W-1:0]     action = '0;
    logic [CHAR_W-1:0]       char_code = '0;
    logic [READ_ROW_W-1:0]   read_row = '0;
    logic [READ_COL_W-1:0]   read_col = '0;
    logic                    color_we = 1'b0;
    logic [COLOR_W-1:0]      color_data = '0;
    logic                    done;
    logic [CELL_VALUE_W-1:0] cell_value;
    logic [CURSOR_ROW_W-1:0] cursor_row;
    logic [CURSOR_COL_W-1:0] cursor_col;

    // Shadow state of the console.
    logic [CELL_VALUE_W-1:0] shadow_cells [0:ROWS*COLS-1];
    logic [COLOR_W-1:0]      shadow_color = TEXT_COLOR_RESET;
    int                      cur_row = 0;
    int                      cur_col = 0;

    console_view_t pending_views [$];
    int            error_count = 0;
    int            request_count = 0;
    int            read_count = 0;
    int            scroll_count = 0;
    int            clear_count = 0;

    // Directed requests; the views typed in assume the reset color of 7.
    directed_row_t directed_table [0:TABLE_ROWS-1] = '{
        '{ACT_PUT,    8'h41,        5'd0,  7'd0,   1'b1, '{16'h0000, 5'd0, 7'd1}},
        '{ACT_READ,   8'h00,        5'd0,  7'd0,   1'b1, '{16'h0741, 5'd0, 7'd1}},
        '{ACT_READ,   8'h00,        5'd25, 7'd0,   1'b1, '{16'h0000, 5'd0, 7'd1}},
        '{ACT_READ,   8'hFF,        5'd0,  7'd80,  1'b1, '{16'h0000, 5'd0, 7'd1}},
        '{ACT_READ,   8'h00,        5'd31, 7'd127, 1'b1, '{16'h0000, 5'd0, 7'd1}},
        '{ACT_UNUSED, 8'hFF,        5'd31, 7'd127, 1'b1, '{16'h0000, 5'd0, 7'd1}},
        '{ACT_CLEAR,  8'hAA,        5'd21, 7'd85,  1'b1, '{16'h0000, 5'd0, 7'd0}},
        '{ACT_READ,   8'h55,        5'd24, 7'd79,  1'b1, '{16'h0720, 5'd0, 7'd0}},
        '{ACT_READ,   8'h00,        5'd0,  7'd0,   1'b1, '{16'h0720, 5'd0, 7'd0}},
        '{ACT_PUT,    8'h00,        5'd31, 7'd127, 1'b1, '{16'h0000, 5'd0, 7'd1}},
        '{ACT_PUT,    8'hFF,        5'd0,  7'd0,   1'b1, '{16'h0000, 5'd0, 7'd2}},
        '{ACT_READ,   8'h00,        5'd0,  7'd1,   1'b1, '{16'h07FF, 5'd0, 7'd2}},
        '{ACT_PUT,    NEWLINE_CODE, 5'd10, 7'd42,  1'b1, '{16'h0000, 5'd1, 7'd0}},
        '{ACT_READ,   8'h00,        5'd0,  7'd2,   1'b1, '{16'h0720, 5'd1, 7'd0}},
        '{ACT_PUT,    NEWLINE_CODE, 5'd0,  7'd0,   1'b1, '{16'h0000, 5'd2, 7'd0}},
        '{ACT_PUT,    8'h7F,        5'd0,  7'd0,   1'b0, NO_VIEW},
        '{ACT_READ,   8'h00,        5'd2,  7'd0,   1'b0, NO_VIEW},
        '{ACT_UNUSED, 8'h00,        5'd0,  7'd0,   1'b1, '{16'h0000, 5'd2, 7'd1}},
        '{ACT_READ,   8'h00,        5'd24, 7'd80,  1'b1, '{16'h0000, 5'd2, 7'd1}},
        '{ACT_CLEAR,  8'h00,        5'd0,  7'd0,   1'b1, '{16'h0000, 5'd0, 7'd0}}
    };

    text_console_writer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .char_code  (char_code),
        .read_row   (read_row),
        .read_col   (read_col),
        .color_we   (color_we),
        .color_data (color_data),
        .done       (done),
        .cell_value (cell_value),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Blank every cell from the given row down with the current color.
    function automatic void blank_from_row(input int first_row);
        for (int i = first_row * COLS; i < ROWS * COLS; i++)
            shadow_cells[i] = {shadow_color, BLANK_CODE};
    endfunction

    // Apply one request to the shadow console and return the result it shows.
    function automatic console_view_t step_console(
        input logic [ACTION_W-1:0]   act,
        input logic [CHAR_W-1:0]     code,
        input logic [READ_ROW_W-1:0] row,
        input logic [READ_COL_W-1:0] col
    );
        console_view_t view;
        view = '0;
        if (act == ACT_PUT)
        begin
            // A newline is not stored, but it always ends the line.
            if (code != NEWLINE_CODE)
                shadow_cells[cur_row * COLS + cur_col] = {shadow_color, code};
            if (code == NEWLINE_CODE || cur_col == COLS - 1)
            begin
                cur_col = 0;
                if (cur_row == ROWS - 1)
                begin
                    // Leaving the last row scrolls the screen up one line.
                    for (int i = 0; i < (ROWS - 1) * COLS; i++)
                        shadow_cells[i] = shadow_cells[i + COLS];
                    blank_from_row(ROWS - 1);
                    scroll_count++;
                end
                else
                begin
                    cur_row++;
                end
            end
            else
            begin
                cur_col++;
            end
        end
        else if (act == ACT_READ)
        begin
            read_count++;
            if (row < ROWS && col < COLS)
                view.cell_value = shadow_cells[row * COLS + col];
        end
        else if (act == ACT_CLEAR)
        begin
            blank_from_row(0);
            cur_row = 0;
            cur_col = 0;
            clear_count++;
        end
        view.cursor_row = cur_row[CURSOR_ROW_W-1:0];
        view.cursor_col = cur_col[CURSOR_COL_W-1:0];
        return view;
    endfunction

    // Present one request, hold it until accepted, then queue its expected view.
    task automatic issue_request(
        input logic [ACTION_W-1:0]   act,
        input logic [CHAR_W-1:0]     code,
        input logic [READ_ROW_W-1:0] row,
        input logic [READ_COL_W-1:0] col,
        input logic                  has_view,
        input console_view_t         typed_view
    );
        console_view_t predicted;
        start     <= 1'b1;
        action    <= act;
        char_code <= code;
        read_row  <= row;
        read_col  <= col;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = step_console(act, code, row, col);
        pending_views.push_back(has_view ? typed_view : predicted);
        request_count++;
    endtask

    // Drop start for a random gap: mostly none or short, now and then long.
    task automatic idle_gap(input bit gaps_on);
        int pick;
        int gap;
        pick = $urandom_range(0, 99);
        if (!gaps_on || pick < 55)
            gap = 0;
        else if (pick < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
    endtask

    // Wait until every queued request has produced its result.
    task automatic drain_requests();
        start <= 1'b0;
        while (pending_views.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    // Compare each result with the oldest expected view.
    always @(posedge clk)
    begin : result_check
        console_view_t want;
        if (rst_n && done)
        begin
            if (pending_views.size() == 0)
            begin
                $error("result with no request waiting: cell_value %h row %0d col %0d",
                       cell_value, cursor_row, cursor_col);
                error_count++;
            end
            else
            begin
                want = pending_views.pop_front();
                if (cell_value !== want.cell_value)
                begin
                    $error("cell_value: expected %h, got %h", want.cell_value, cell_value);
                    error_count++;
                end
                if (cursor_row !== want.cursor_row)
                begin
                    $error("cursor_row: expected %0d, got %0d", want.cursor_row, cursor_row);
                    error_count++;
                end
                if (cursor_col !== want.cursor_col)
                begin
                    $error("cursor_col: expected %0d, got %0d", want.cursor_col, cursor_col);
                    error_count++;
                end
            end
        end
    end

    // End the run if neither a request nor a result moves for too long.
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (start && !busy) || done)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $error("nothing moved for %0d cycles", STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // Stimulus: reset, directed table, then random phases under several colors.
    initial
    begin : stimulus
        logic [ACTION_W-1:0]   act;
        logic [CHAR_W-1:0]     code;
        logic [READ_ROW_W-1:0] row;
        logic [READ_COL_W-1:0] col;
        logic [COLOR_W-1:0]    next_color;
        int                    kind;
        int                    newline_pct;
        bit                    gaps_on;

        newline_pct = 0;
        gaps_on = 1'b1;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part runs under the reset color.
        for (int i = 0; i < TABLE_ROWS; i++)
        begin
            issue_request(directed_table[i].act, directed_table[i].code,
                          directed_table[i].row, directed_table[i].col,
                          directed_table[i].has_view, directed_table[i].view);
            idle_gap(i % 2 == 0);
        end

        for (int phase = 0; phase < COLOR_PHASES; phase++)
        begin
            // Change the color only while the block is idle.
            drain_requests();
            if (phase == 0)
                next_color = 8'h00;
            else if (phase == 1)
                next_color = 8'hFF;
            else
                next_color = COLOR_W'($urandom_range(1, 254));
            color_we   <= 1'b1;
            color_data <= next_color;
            @(posedge clk);
            shadow_color = next_color;
            color_we <= 1'b0;

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Each segment picks a line style and whether gaps occur.
                if (n % SEGMENT_ITEMS == 0)
                begin
                    case ($urandom_range(0, 2))
                        0:       newline_pct = 0;
                        1:       newline_pct = 4;
                        default: newline_pct = 30;
                    endcase
                    gaps_on = ($urandom_range(0, 3) != 0);
                end
                kind = $urandom_range(0, 999);
                code = CHAR_W'($urandom_range(0, 255));
                row  = READ_ROW_W'($urandom_range(0, 31));
                col  = READ_COL_W'($urandom_range(0, 127));
                if (kind < 680)
                begin
                    act = ACT_PUT;
                    if ($urandom_range(0, 99) < newline_pct)
                        code = NEWLINE_CODE;
                end
                else if (kind < 880)
                begin
                    act = ACT_READ;
                    row = READ_ROW_W'($urandom_range(0, ROWS - 1));
                    col = READ_COL_W'($urandom_range(0, COLS - 1));
                end
                else if (kind < 930)
                begin
                    // Read outside the grid in one coordinate or the other.
                    act = ACT_READ;
                    if ($urandom_range(0, 1) == 0)
                        row = READ_ROW_W'($urandom_range(ROWS, 31));
                    else
                        col = READ_COL_W'($urandom_range(COLS, 127));
                end
                else if (kind < 994)
                begin
                    act = ACT_UNUSED;
                end
                else
                begin
                    act = ACT_CLEAR;
                end
                issue_request(act, code, row, col, 1'b0, NO_VIEW);
                idle_gap(gaps_on);
            end
        end

        drain_requests();
        repeat (20)
            @(posedge clk);
        $display("Ran %0d requests: %0d reads, %0d scrolls, %0d clears.",
                 request_count, read_count, scroll_count, clear_count);
        $display("Text colors used: reset value, 00, ff and %0d random values.",
                 COLOR_PHASES - 2);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/tcw_pkg.sv
rtl/core/tcw_front.sv
rtl/core/tcw_cmd_fifo.sv
rtl/core/tcw_back.sv
rtl/core/text_console_writer.sv
rtl/core/tcw_checker.sv
bench/tb_text_console_writer.sv
